>>> rtl/rbbg_pkg.sv
`timescale 1ns / 1ps

package rbbg_pkg;

   localparam int RADIUS  = 10;
   localparam int WIN_LEN = 2 * RADIUS + 1;
   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int CNT_W   = $clog2(WIN_LEN + 1);
   localparam int AGE_W   = $clog2(WIN_LEN);
   localparam int SUM_W   = $clog2(WIN_LEN * ((1 << CH_W) - 1) + 1);
   localparam int STEP_W  = $clog2(SUM_W);

   // gray = floor(x / 3) for x <= 765 via x * 683 >> 11
   localparam int SUM3_W     = CH_W + 2;
   localparam int GRAY_MUL   = 683;
   localparam int GRAY_SHIFT = 11;
   localparam int PROD_W     = SUM3_W + GRAY_SHIFT;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_ACC,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic acc_init;
      logic acc_step;
      logic div_step;
      logic emit;
      logic enter_flush;
      logic t_dec;
      logic row_done;
   } cmd_type;

   typedef struct packed {
      logic n_gt_radius;
      logic last;
      logic flush;
      logic t_zero;
      logic acc_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

>>> rtl/rbbg_ctrl.sv
`timescale 1ns / 1ps

module rbbg_ctrl import rbbg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (status.flush || status.n_gt_radius) begin
               cmd.acc_init = 1'b1;
               state_in     = ST_ACC;
            end else if (status.last) begin
               cmd.enter_flush = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ACC: begin
            cmd.acc_step = 1'b1;
            if (status.acc_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.flush) begin
                  if (status.t_zero) begin
                     cmd.row_done = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.t_dec = 1'b1;
                     state_in  = ST_PICK;
                  end
               end else if (status.last) begin
                  cmd.enter_flush = 1'b1;
                  state_in        = ST_PICK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/rbbg_dp.sv
`timescale 1ns / 1ps

module rbbg_dp import rbbg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [CH_W-1:0]   req_red,
   input  logic [CH_W-1:0]   req_green,
   input  logic [CH_W-1:0]   req_blue,
   input  logic              req_row_end,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CH_W-1:0]   rsp_gray,
   output logic              rsp_row_last
);

   // window: entry 0 is the newest pixel
   logic [PIX_W-1:0]  win_ff [WIN_LEN];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              last_ff, last_in;
   logic              flush_ff, flush_in;
   logic [AGE_W-1:0]  t_ff, t_in;
   logic [AGE_W-1:0]  age_ff, age_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  sum_ff [3];
   logic [SUM_W-1:0]  sum_in [3];
   logic [CNT_W-1:0]  rem_ff [3];
   logic [CNT_W-1:0]  rem_in [3];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]   rsp_gray_ff, rsp_gray_in;
   logic              rsp_row_last_ff, rsp_row_last_in;

   logic [CNT_W-1:0]  count_nx;
   logic [CNT_W-1:0]  cnt_m1;
   logic [AGE_W-1:0]  t_reach;
   logic [AGE_W-1:0]  hi;
   logic [CNT_W-1:0]  win_n;
   logic [PIX_W-1:0]  pix;
   logic [CNT_W:0]    trial [3];
   logic [SUM3_W-1:0] sum3;
   logic [PROD_W-1:0] prod;
   logic              out_free;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         win_ff[0] <= {req_red, req_green, req_blue};
         for (int i = 1; i < WIN_LEN; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   always_comb begin
      count_nx = (count_ff == CNT_W'(WIN_LEN)) ? count_ff : count_ff + CNT_W'(1);
      cnt_m1   = count_ff - CNT_W'(1);
      t_reach  = t_ff + AGE_W'(RADIUS);
      if (flush_ff && (CNT_W'(t_reach) < cnt_m1)) begin
         hi = t_reach;
      end else begin
         hi = AGE_W'(cnt_m1);
      end
      win_n    = CNT_W'(hi) + CNT_W'(1);
      pix      = win_ff[age_ff];
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      count_in = count_ff;
      last_in  = last_ff;
      flush_in = flush_ff;
      t_in     = t_ff;
      if (cmd.load) begin
         count_in = count_nx;
         last_in  = req_row_end;
         flush_in = 1'b0;
         if ((count_nx - CNT_W'(1)) < CNT_W'(RADIUS - 1)) begin
            t_in = AGE_W'(count_nx - CNT_W'(1));
         end else begin
            t_in = AGE_W'(RADIUS - 1);
         end
      end
      if (cmd.enter_flush) begin
         flush_in = 1'b1;
      end
      if (cmd.t_dec) begin
         t_in = t_ff - AGE_W'(1);
      end
      if (cmd.row_done) begin
         count_in = '0;
         flush_in = 1'b0;
      end
   end

   always_comb begin
      age_in  = age_ff;
      step_in = step_ff;
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = sum_ff[c];
         rem_in[c] = rem_ff[c];
         trial[c]  = {rem_ff[c], sum_ff[c][SUM_W-1]};
      end
      if (cmd.acc_init) begin
         age_in  = '0;
         step_in = '0;
         for (int c = 0; c < 3; c++) begin
            sum_in[c] = '0;
            rem_in[c] = '0;
         end
      end
      if (cmd.acc_step) begin
         age_in = age_ff + AGE_W'(1);
         for (int c = 0; c < 3; c++) begin
            sum_in[c] = sum_ff[c] + SUM_W'(pix[(2-c)*CH_W +: CH_W]);
         end
      end
      // restoring divide by the window count, quotient shifts into the sum
      if (cmd.div_step) begin
         step_in = step_ff + STEP_W'(1);
         for (int c = 0; c < 3; c++) begin
            if (trial[c] >= {1'b0, win_n}) begin
               rem_in[c] = CNT_W'(trial[c] - {1'b0, win_n});
               sum_in[c] = {sum_ff[c][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[c] = CNT_W'(trial[c]);
               sum_in[c] = {sum_ff[c][SUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      sum3 = SUM3_W'(sum_ff[0][CH_W-1:0]) + SUM3_W'(sum_ff[1][CH_W-1:0])
           + SUM3_W'(sum_ff[2][CH_W-1:0]);
      prod = PROD_W'(sum3) * PROD_W'(GRAY_MUL);
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_gray_in     = rsp_gray_ff;
      rsp_row_last_in = rsp_row_last_ff;
      if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_gray_in     = prod[GRAY_SHIFT +: CH_W];
         rsp_row_last_in = flush_ff && (t_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_ff      <= 1'b0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         last_ff      <= last_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff            <= t_in;
      age_ff          <= age_in;
      step_ff         <= step_in;
      rsp_gray_ff     <= rsp_gray_in;
      rsp_row_last_ff <= rsp_row_last_in;
      for (int c = 0; c < 3; c++) begin
         sum_ff[c] <= sum_in[c];
         rem_ff[c] <= rem_in[c];
      end
   end

   always_comb begin
      status.n_gt_radius = count_ff > CNT_W'(RADIUS);
      status.last        = last_ff;
      status.flush       = flush_ff;
      status.t_zero      = t_ff == '0;
      status.acc_done    = age_ff == hi;
      status.div_done    = step_ff == STEP_W'(SUM_W - 1);
      status.out_free    = out_free;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gray     = rsp_gray_ff;
   assign rsp_row_last = rsp_row_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WIN_LEN))
      else $error("column count beyond window");

   a_age_in_row: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_step |-> (CNT_W'(age_ff) < count_ff))
      else $error("window read beyond pixels of the row");

   a_flush_t: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> (t_ff < AGE_W'(RADIUS)))
      else $error("flush column out of range");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("word emitted over a pending word");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !flush_ff) |=> !rsp_row_last_ff)
      else $error("row_last set on a normal word");

endmodule

>>> rtl/row_box_blur_then_gray.sv
`timescale 1ns / 1ps
// channel | ports                                   | direction
// req     | req_red/green/blue, req_row_end         | in,  valid/ready
// rsp     | rsp_gray, rsp_row_last                  | out, valid/ready
//
// One pixel word is taken at a time. Each result passes a pick state, accumulates
// over the window register (up to 21 pixels), takes 13 restoring-divide steps shared
// by the three channels and ends in an output state that waits for a free output register.
// A row end word yields up to 11 results in turn; a short row enters flush from the pick state first.
// Synchronous active-high reset clears control; the window is not cleared.
// A stalled rsp holds one word in the output register while the next is built.
module row_box_blur_then_gray import rbbg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [CH_W-1:0] req_red,
   input  logic [CH_W-1:0] req_green,
   input  logic [CH_W-1:0] req_blue,
   input  logic            req_row_end,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [CH_W-1:0] rsp_gray,
   output logic            rsp_row_last
);

   cmd_type    cmd;
   status_type status;

   rbbg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rbbg_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .req_row_end  (req_row_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gray     (rsp_gray),
      .rsp_row_last (rsp_row_last)
   );

endmodule

>>> bench/rbbg_checker.sv
`timescale 1ns / 1ps

module rbbg_checker import rbbg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  logic [CH_W-1:0] req_red,
   input  logic [CH_W-1:0] req_green,
   input  logic [CH_W-1:0] req_blue,
   input  logic            req_row_end,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic [CH_W-1:0] rsp_gray,
   input  logic            rsp_row_last,
   output int              fail_count,
   output int              pending_words,
   output int              checked_words
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CH_W-1:0] gray;
      logic            row_last;
   } gray_word_type;

   gray_word_type    gray_due[$];
   gray_word_type    oldest;
   logic [PIX_W-1:0] row_pixels [WIN_LEN];
   int               row_fill;
   int               ring_pos;
   int               fails;
   int               checked;

   // blurred gray of the window holding the newest span+1 pixels
   function automatic logic [CH_W-1:0] window_gray(int span);
      int               red_acc;
      int               green_acc;
      int               blue_acc;
      int               age;
      int               n;
      logic [PIX_W-1:0] px;
      red_acc   = 0;
      green_acc = 0;
      blue_acc  = 0;
      for (age = 0; age <= span; age++) begin
         px = row_pixels[(ring_pos + WIN_LEN - 1 - age) % WIN_LEN];
         red_acc   += int'(px[3*CH_W-1:2*CH_W]);
         green_acc += int'(px[2*CH_W-1:CH_W]);
         blue_acc  += int'(px[CH_W-1:0]);
      end
      n = span + 1;
      return CH_W'((red_acc / n + green_acc / n + blue_acc / n) / 3);
   endfunction

   task automatic queue_word(input logic [CH_W-1:0] gray, input logic row_last);
      gray_word_type word;
      word.gray     = gray;
      word.row_last = row_last;
      gray_due.insert(gray_due.size(), word);
   endtask

   task automatic predict_gray_words(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                     input logic [CH_W-1:0] b, input logic last);
      int span;
      int t;
      row_pixels[ring_pos] = {r, g, b};
      ring_pos = (ring_pos + 1) % WIN_LEN;
      if (row_fill < WIN_LEN) begin
         row_fill++;
      end
      if (row_fill > RADIUS) begin
         span = (row_fill - 1 > 2 * RADIUS) ? 2 * RADIUS : row_fill - 1;
         queue_word(window_gray(span), 1'b0);
      end
      if (last) begin
         // flush: remaining columns, oldest first
         for (t = (row_fill - 1 < RADIUS - 1) ? row_fill - 1 : RADIUS - 1; t >= 0; t--) begin
            span = (t + RADIUS > row_fill - 1) ? row_fill - 1 : t + RADIUS;
            queue_word(window_gray(span), t == 0);
         end
         row_fill = 0;
         ring_pos = 0;
      end
   endtask

   task automatic note_mismatch(input string what);
      fails++;
      if (fails <= REPORT_LIMIT) begin
         $display("%t: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gray_due.delete();
         row_fill = 0;
         ring_pos = 0;
      end else begin
         // a word leaving now never stems from a word taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (gray_due.size() == 0) begin
               note_mismatch($sformatf("unexpected word: gray %0d row_last %0b",
                                       rsp_gray, rsp_row_last));
            end else begin
               oldest = gray_due.pop_front();
               checked++;
               if (oldest.gray !== rsp_gray || oldest.row_last !== rsp_row_last) begin
                  note_mismatch($sformatf(
                     "word %0d: expected gray %0d row_last %0b, got gray %0d row_last %0b",
                     checked, oldest.gray, oldest.row_last, rsp_gray, rsp_row_last));
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_gray_words(req_red, req_green, req_blue, req_row_end);
         end
      end
      fail_count    <= fails;
      pending_words <= gray_due.size();
      checked_words <= checked;
   end

endmodule

>>> bench/row_box_blur_then_gray_tb.sv
`timescale 1ns / 1ps

module row_box_blur_then_gray_tb;
   import rbbg_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int RANDOM_PIXELS = 370;
   localparam int MAX_GAP       = 11;

   typedef enum int {
      FILL_RANDOM,
      FILL_EXTREME,
      FILL_MAX,
      FILL_ZERO,
      FILL_RAMP
   } fill_kind_type;

   logic            clock        = 1'b0;
   logic            reset        = 1'b1;
   logic            req_valid    = 1'b0;
   logic            req_ready;
   logic [CH_W-1:0] req_red      = '0;
   logic [CH_W-1:0] req_green    = '0;
   logic [CH_W-1:0] req_blue     = '0;
   logic            req_row_end  = 1'b0;
   logic            rsp_valid;
   logic            rsp_ready    = 1'b0;
   logic [CH_W-1:0] rsp_gray;
   logic            rsp_row_last;

   int fail_count;
   int pending_words;
   int checked_words;
   int cycles;
   int pixels_sent;
   int rows_sent;
   int longest_row;
   bit req_calm;
   bit rsp_calm;

   row_box_blur_then_gray i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .req_row_end  (req_row_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_gray     (rsp_gray),
      .rsp_row_last (rsp_row_last)
   );

   rbbg_checker i_gray_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_row_end   (req_row_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_gray      (rsp_gray),
      .rsp_row_last  (rsp_row_last),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .checked_words (checked_words)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_words);
         $display("row_box_blur_then_gray: mismatch");
         $finish;
      end
   end

   function automatic int pick_gap(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // rsp side: a random stall, possibly none, before each word, with quiet stretches
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            rsp_calm = !rsp_calm;
         end
         gap = pick_gap(rsp_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic push_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b, input logic last);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_red     <= r;
      req_green   <= g;
      req_blue    <= b;
      req_row_end <= last;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   task automatic send_row(input int length, input fill_kind_type fill);
      logic [CH_W-1:0] r;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] b;
      int              col;
      req_calm = ($urandom_range(0, 3) == 0);
      for (col = 0; col < length; col++) begin
         case (fill)
            FILL_EXTREME: begin
               r = $urandom_range(0, 1) ? '1 : '0;
               g = $urandom_range(0, 1) ? '1 : '0;
               b = $urandom_range(0, 1) ? '1 : '0;
            end
            FILL_MAX: begin
               r = '1;
               g = '1;
               b = '1;
            end
            FILL_ZERO: begin
               r = '0;
               g = '0;
               b = '0;
            end
            FILL_RAMP: begin
               r = CH_W'(col * 23);
               g = CH_W'(255 - col * 11);
               b = CH_W'(col * col);
            end
            default: begin
               r = CH_W'($urandom);
               g = CH_W'($urandom);
               b = CH_W'($urandom);
            end
         endcase
         push_pixel(r, g, b, col == length - 1);
      end
      rows_sent++;
      if (length > longest_row) begin
         longest_row = length;
      end
   endtask

   initial begin
      int            random_sent;
      int            length;
      int            pick;
      fill_kind_type fill;
      random_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single-pixel rows, tiny row, short row, shortest row with a non-flush word
      send_row(1, FILL_MAX);
      send_row(1, FILL_ZERO);
      send_row(2, FILL_EXTREME);
      send_row(RADIUS, FILL_RAMP);
      send_row(RADIUS + 1, FILL_RANDOM);

      while (random_sent < RANDOM_PIXELS) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            length = $urandom_range(1, RADIUS);
         end else if (pick < 6) begin
            length = $urandom_range(RADIUS + 1, WIN_LEN + 1);
         end else if (pick < 9) begin
            length = $urandom_range(WIN_LEN + 2, 60);
         end else begin
            length = 1;
         end
         pick = $urandom_range(0, 7);
         fill = (pick > 4) ? FILL_RANDOM : fill_kind_type'(pick);
         send_row(length, fill);
         random_sent += length;
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_words != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d pixel words in %0d rows sent, row lengths from 1 up to %0d",
               pixels_sent, rows_sent, longest_row);
      $display("%0d gray words checked, %0d failures", checked_words, fail_count);
      if (fail_count == 0 && pending_words == 0) begin
         $display("row_box_blur_then_gray: match");
      end else begin
         $display("row_box_blur_then_gray: mismatch");
      end
      $finish;
   end

endmodule

>>> row_box_blur_then_gray.f
rtl/rbbg_pkg.sv
rtl/rbbg_ctrl.sv
rtl/rbbg_dp.sv
rtl/row_box_blur_then_gray.sv
bench/rbbg_checker.sv
bench/row_box_blur_then_gray_tb.sv
